// ===== rtl/core/mbe_pkg.sv =====
// shared types, constants and width helpers for the color expansion blitter
`default_nettype none

package mbe_pkg;

   // default geometry
   localparam int SCREEN_WIDTH_DEF  = 320;
   localparam int SCREEN_HEIGHT_DEF = 200;
   localparam int MAX_SIDE_DEF      = 1024;

   // fixed field widths
   localparam int ADDR_W     = 32;
   localparam int COORD_W    = 12;
   localparam int SIDE_REG_W = 11;
   localparam int COLOR_W    = 8;
   localparam int BYTE_W     = 8;
   localparam int LANES      = 8;
   localparam int LANE_IDX_W = 3;
   localparam int CNT_W      = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ENABLED     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_FB_BASE     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_DEST_X      = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_DEST_Y      = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_BLIT_WIDTH  = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_BLIT_HEIGHT = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] REG_FG_INDEX    = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] REG_BG_INDEX    = CSR_IDX_W'(7);

   typedef struct packed {
      logic                      enabled;
      logic [ADDR_W-1:0]         fb_base;
      logic signed [COORD_W-1:0] dest_x;
      logic signed [COORD_W-1:0] dest_y;
      logic [SIDE_REG_W-1:0]     blit_width;
      logic [SIDE_REG_W-1:0]     blit_height;
      logic [COLOR_W-1:0]        fg_index;
      logic [COLOR_W-1:0]        bg_index;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      enabled:     1'b0,
      fb_base:     32'h000A_0000,
      dest_x:      '0,
      dest_y:      '0,
      blit_width:  '0,
      blit_height: '0,
      fg_index:    8'hFF,
      bg_index:    8'h00
   };

   // per-byte control that rides along the pipeline
   typedef struct packed {
      logic [BYTE_W-1:0] bits;
      logic [CNT_W-1:0]  pixel_count;
      logic              last_byte;
   } byte_ctl_type;

   typedef struct packed {
      logic               write_enable;
      logic [ADDR_W-1:0]  pixel_address;
      logic [COLOR_W-1:0] color_index;
   } pixel_type;

   // largest side the size registers can express after clamping
   function automatic int eff_side(input int max_side);
      return (max_side < (2 ** SIDE_REG_W) - 1) ? max_side : (2 ** SIDE_REG_W) - 1;
   endfunction

   function automatic int side_width(input int max_side);
      return $clog2(eff_side(max_side) + 1);
   endfunction

   function automatic int row_width(input int max_side);
      return $clog2(eff_side(max_side));
   endfunction

   function automatic int bpr_max(input int max_side);
      return (eff_side(max_side) + 7) >> 3;
   endfunction

   function automatic int bc_width(input int max_side);
      return (bpr_max(max_side) > 1) ? $clog2(bpr_max(max_side)) : 1;
   endfunction

   function automatic int bpr_width(input int max_side);
      return $clog2(bpr_max(max_side) + 1);
   endfunction

   function automatic int col_width(input int max_side);
      return bc_width(max_side) + 3;
   endfunction

   // signed width holding a 12-bit signed origin plus a bitmap offset
   function automatic int pos_width(input int max_side);
      int off_w;
      off_w = (row_width(max_side) > col_width(max_side)) ?
              row_width(max_side) : col_width(max_side);
      return ((off_w + 1 > COORD_W) ? off_w + 1 : COORD_W) + 1;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mbe_intf.sv =====
// bitmap word and pixel word channel interfaces
`default_nettype none

interface mbe_req_if;
   logic                      valid;
   logic                      ready;
   logic [mbe_pkg::BYTE_W-1:0] bitmap_byte;

   modport source (output valid, output bitmap_byte, input ready);
   modport sink   (input valid, input bitmap_byte, output ready);
endinterface

interface mbe_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        write_enable;
   logic [mbe_pkg::ADDR_W-1:0]  pixel_address;
   logic [mbe_pkg::COLOR_W-1:0] color_index;
   logic                        last_of_byte;
   logic                        blit_done;

   modport source (output valid, output write_enable, output pixel_address,
                   output color_index, output last_of_byte, output blit_done,
                   input ready);
   modport sink   (input valid, input write_enable, input pixel_address,
                   input color_index, input last_of_byte, input blit_done,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mbe_walk.sv =====
// bitmap position tracker: byte and row counters, per-byte decode register
`default_nettype none

module mbe_walk #(
   parameter int  MAX_SIDE = mbe_pkg::MAX_SIDE_DEF,
   localparam int POS_W    = mbe_pkg::pos_width(MAX_SIDE),
   localparam int COL_W    = mbe_pkg::col_width(MAX_SIDE)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mbe_pkg::cfg_type              cfg,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic [mbe_pkg::BYTE_W-1:0]    in_bits,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output mbe_pkg::byte_ctl_type              out_ctl,
   output logic signed [POS_W-1:0]            out_y,
   output logic [COL_W-1:0]                   out_col0
);
   import mbe_pkg::*;

   localparam int EFF   = eff_side(MAX_SIDE);
   localparam int SIDE_W = side_width(MAX_SIDE);
   localparam int ROW_W = row_width(MAX_SIDE);
   localparam int BC_W  = bc_width(MAX_SIDE);
   localparam int BPR_W = bpr_width(MAX_SIDE);
   localparam int REM_W = SIDE_W + 1;

   logic [BC_W-1:0]  bc_ff, bc_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             valid_ff, valid_in;
   byte_ctl_type     ctl_ff, ctl_in;
   logic signed [POS_W-1:0] y_ff, y_in;
   logic [COL_W-1:0] col0_ff, col0_in;

   logic [SIDE_REG_W-1:0] side_lim;
   logic [SIDE_W-1:0] w, h;
   logic              empty;
   logic [REM_W-1:0]  w_pad, rem;
   logic [BPR_W-1:0]  bpr, bc_nxt;
   logic              bc_wrap, row_ovf, row_end, last_row, accept;
   logic [SIDE_W-1:0] row_a, row_nxt;
   logic [BC_W-1:0]   bc_b;
   logic [ROW_W-1:0]  row_b;
   logic [CNT_W-1:0]  n;

   always_comb begin
      side_lim = SIDE_REG_W'(EFF);
      w = SIDE_W'((cfg.blit_width  > side_lim) ? side_lim : cfg.blit_width);
      h = SIDE_W'((cfg.blit_height > side_lim) ? side_lim : cfg.blit_height);
      empty = (w == '0) || (h == '0);
      w_pad = REM_W'(w) + REM_W'(7);
      bpr = BPR_W'(w_pad >> 3);

      // stale position after a size change: wrap before use
      bc_wrap = BPR_W'(bc_ff) >= bpr;
      row_a = SIDE_W'(row_ff) + (bc_wrap ? SIDE_W'(1) : SIDE_W'(0));
      row_ovf = row_a >= h;
      bc_b = (bc_wrap || row_ovf) ? '0 : bc_ff;
      row_b = row_ovf ? '0 : ROW_W'(row_a);

      bc_nxt = BPR_W'(bc_b) + BPR_W'(1);
      row_nxt = SIDE_W'(row_b) + SIDE_W'(1);
      row_end = bc_nxt == bpr;
      last_row = row_nxt == h;

      col0_in = {bc_b, 3'b000};
      rem = REM_W'(w) - REM_W'(col0_in);
      n = (rem > REM_W'(LANES)) ? CNT_W'(LANES) : CNT_W'(rem);

      ctl_in.bits = in_bits;
      ctl_in.pixel_count = n;
      ctl_in.last_byte = row_end && last_row;
      y_in = POS_W'(cfg.dest_y) + POS_W'(row_b);

      in_ready = !valid_ff || out_ready;
      accept = in_valid && in_ready;

      bc_in = bc_ff;
      row_in = row_ff;
      if (accept && !empty) begin
         if (row_end) begin
            bc_in = '0;
            row_in = last_row ? '0 : ROW_W'(row_nxt);
         end else begin
            bc_in = BC_W'(bc_nxt);
            row_in = row_b;
         end
      end

      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = accept && !empty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bc_ff <= '0;
         row_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         bc_ff <= bc_in;
         row_ff <= row_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ctl_ff <= ctl_in;
         y_ff <= y_in;
         col0_ff <= col0_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl = ctl_ff;
   assign out_y = y_ff;
   assign out_col0 = col0_ff;

endmodule

`default_nettype wire

// ===== rtl/core/mbe_rowaddr.sv =====
// row address pipeline: y times screen width, then framebuffer base
`default_nettype none

module mbe_rowaddr #(
   parameter int  SCREEN_WIDTH  = mbe_pkg::SCREEN_WIDTH_DEF,
   parameter int  SCREEN_HEIGHT = mbe_pkg::SCREEN_HEIGHT_DEF,
   parameter int  MAX_SIDE      = mbe_pkg::MAX_SIDE_DEF,
   localparam int POS_W         = mbe_pkg::pos_width(MAX_SIDE),
   localparam int COL_W         = mbe_pkg::col_width(MAX_SIDE)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [mbe_pkg::ADDR_W-1:0]  fb_base,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire mbe_pkg::byte_ctl_type       in_ctl,
   input  wire logic signed [POS_W-1:0]     in_y,
   input  wire logic [COL_W-1:0]            in_col0,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output mbe_pkg::byte_ctl_type            out_ctl,
   output logic [COL_W-1:0]                 out_col0,
   output logic [mbe_pkg::ADDR_W-1:0]       out_row_addr,
   output logic                             out_row_on
);
   import mbe_pkg::*;

   localparam int SWS_W  = $clog2(SCREEN_WIDTH + 1) + 1;
   localparam int PROD_W = POS_W + SWS_W;
   localparam int SHC_W  = $clog2(SCREEN_HEIGHT + 1);
   localparam int CMP_W  = (POS_W > SHC_W) ? POS_W : SHC_W;
   localparam logic signed [SWS_W-1:0] SW_S = SWS_W'(SCREEN_WIDTH);

   logic                     v2_ff, v3_ff, load2, load3;
   byte_ctl_type             ctl2_ff, ctl3_ff;
   logic [COL_W-1:0]         col2_ff, col3_ff;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic                     on2_in, on2_ff, on3_ff;
   logic [ADDR_W-1:0]        addr3_in, addr3_ff;

   always_comb begin
      load3 = !v3_ff || out_ready;
      load2 = !v2_ff || load3;
      in_ready = load2;
      prod_in = PROD_W'(in_y) * PROD_W'(SW_S);
      on2_in = !in_y[POS_W-1] &&
               (CMP_W'($unsigned(in_y)) < CMP_W'(SCREEN_HEIGHT));
      addr3_in = fb_base + ADDR_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (load2) begin
            v2_ff <= in_valid;
         end
         if (load3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load2 && in_valid) begin
         ctl2_ff <= in_ctl;
         col2_ff <= in_col0;
         prod_ff <= prod_in;
         on2_ff <= on2_in;
      end
      if (load3 && v2_ff) begin
         ctl3_ff <= ctl2_ff;
         col3_ff <= col2_ff;
         addr3_ff <= addr3_in;
         on3_ff <= on2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_ctl = ctl3_ff;
   assign out_col0 = col3_ff;
   assign out_row_addr = addr3_ff;
   assign out_row_on = on3_ff;

endmodule

`default_nettype wire

// ===== rtl/core/mbe_lane.sv =====
// one pixel lane: column, clip test, address and color for one bitmap bit
`default_nettype none

module mbe_lane #(
   parameter int  SCREEN_WIDTH = mbe_pkg::SCREEN_WIDTH_DEF,
   parameter int  MAX_SIDE     = mbe_pkg::MAX_SIDE_DEF,
   localparam int POS_W        = mbe_pkg::pos_width(MAX_SIDE),
   localparam int COL_W        = mbe_pkg::col_width(MAX_SIDE)
) (
   input  wire logic [mbe_pkg::LANE_IDX_W-1:0]    lane_idx,
   input  wire logic                              pixel_bit,
   input  wire logic [COL_W-1:0]                  col0,
   input  wire logic signed [mbe_pkg::COORD_W-1:0] dest_x,
   input  wire logic [mbe_pkg::ADDR_W-1:0]        row_addr,
   input  wire logic                              row_on,
   input  wire logic [mbe_pkg::COLOR_W-1:0]       fg_index,
   input  wire logic [mbe_pkg::COLOR_W-1:0]       bg_index,
   output mbe_pkg::pixel_type                     px
);
   import mbe_pkg::*;

   localparam int SWC_W = $clog2(SCREEN_WIDTH + 1);
   localparam int CMP_W = (POS_W > SWC_W) ? POS_W : SWC_W;

   logic [COL_W-1:0]        col;
   logic signed [POS_W-1:0] x;
   logic                    x_on;

   always_comb begin
      // col0 has its low three bits clear
      col = col0 | COL_W'(lane_idx);
      x = POS_W'(dest_x) + POS_W'(col);
      x_on = !x[POS_W-1] && (CMP_W'($unsigned(x)) < CMP_W'(SCREEN_WIDTH));
      px.write_enable = row_on && x_on;
      px.pixel_address = row_addr + ADDR_W'(x);
      px.color_index = pixel_bit ? fg_index : bg_index;
   end

endmodule

`default_nettype wire

// ===== rtl/core/mbe_merge.sv =====
// pixel buffer: collects the lane results of one byte and sends them in order
`default_nettype none

module mbe_merge (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire mbe_pkg::byte_ctl_type    in_ctl,
   input  wire mbe_pkg::pixel_type       in_px [mbe_pkg::LANES],
   mbe_rsp_if.source                     rsp
);
   import mbe_pkg::*;

   pixel_type             pix_ff [LANES];
   logic                  valid_ff, valid_in;
   logic [LANE_IDX_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0]      n_ff;
   logic                  last_byte_ff;
   logic                  take, last_pix, final_take, load;
   pixel_type             cur;

   always_comb begin
      cur = pix_ff[ptr_ff];
      last_pix = (CNT_W'(ptr_ff) + CNT_W'(1)) == n_ff;
      take = valid_ff && rsp.ready;
      final_take = take && last_pix;
      in_ready = !valid_ff || final_take;
      load = in_valid && in_ready;

      valid_in = valid_ff;
      ptr_in = ptr_ff;
      if (load) begin
         valid_in = 1'b1;
         ptr_in = '0;
      end else if (final_take) begin
         valid_in = 1'b0;
      end else if (take) begin
         ptr_in = ptr_ff + LANE_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ptr_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         ptr_ff <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pix_ff <= in_px;
         n_ff <= in_ctl.pixel_count;
         last_byte_ff <= in_ctl.last_byte;
      end
   end

   assign rsp.valid = valid_ff;
   assign rsp.write_enable = cur.write_enable;
   assign rsp.pixel_address = cur.pixel_address;
   assign rsp.color_index = cur.color_index;
   assign rsp.last_of_byte = last_pix;
   assign rsp.blit_done = last_pix && last_byte_ff;

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (n_ff != '0) && (n_ff <= CNT_W'(LANES)))
      else $error("pixel buffer holds a byte with a bad pixel count");

   a_ptr_in_byte: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (CNT_W'(ptr_ff) < n_ff))
      else $error("pixel pointer ran past the byte");

   a_ptr_step: assert property (@(posedge clock) disable iff (reset)
      (take && !last_pix) |=> valid_ff && (ptr_ff == $past(ptr_ff) + LANE_IDX_W'(1)))
      else $error("pixel pointer did not advance by one");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (final_take && !in_valid) |=> !valid_ff)
      else $error("pixel buffer still busy after its last pixel");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/mono_bitmap_expand_blit.sv =====
// top level of the monochrome color expansion blitter
//
//   channel  dir  handshake        word carried
//   req      in   valid / ready    bitmap_byte: eight pixels, bit 7 leftmost
//   rsp      out  valid / ready    write_enable, pixel_address, color_index,
//                                  last_of_byte, blit_done
//   csr      in   write enable     register index and write data
//
// each byte gives one to eight pixel words, one per clock on rsp while rsp is
// ready; the single pixel buffer read port sets that rate
// a byte travels registered decode, multiply and address stages before it
// reaches the buffer, which then drives its pixel words on rsp
// three stages plus the buffer absorb bytes while rsp is stalled; bytes given
// while the bitmap is empty are taken on ready and produce nothing
// reset is synchronous: it clears the pipeline, the counters and the registers
`default_nettype none

module mono_bitmap_expand_blit #(
   parameter int SCREEN_WIDTH  = mbe_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = mbe_pkg::SCREEN_HEIGHT_DEF,
   parameter int MAX_SIDE      = mbe_pkg::MAX_SIDE_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   mbe_req_if.sink                              req,
   mbe_rsp_if.source                            rsp,
   input  wire logic                            csr_write_enable,
   input  wire logic [mbe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [mbe_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mbe_pkg::*;

   localparam int POS_W = pos_width(MAX_SIDE);
   localparam int COL_W = col_width(MAX_SIDE);

   // configuration registers
   cfg_type cfg_ff, cfg_in;

   // walk stage to row address pipeline
   logic                    s1_valid, s1_ready;
   byte_ctl_type            s1_ctl;
   logic signed [POS_W-1:0] s1_y;
   logic [COL_W-1:0]        s1_col0;

   // row address pipeline to lanes and buffer
   logic              s3_valid, s3_ready;
   byte_ctl_type      s3_ctl;
   logic [COL_W-1:0]  s3_col0;
   logic [ADDR_W-1:0] s3_row_addr;
   logic              s3_row_on;

   pixel_type lane_px [LANES];

   // register writes, masked to each register's width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_ENABLED:     cfg_in.enabled = csr_wdata[0];
            REG_FB_BASE:     cfg_in.fb_base = csr_wdata[ADDR_W-1:0];
            REG_DEST_X:      cfg_in.dest_x = csr_wdata[COORD_W-1:0];
            REG_DEST_Y:      cfg_in.dest_y = csr_wdata[COORD_W-1:0];
            REG_BLIT_WIDTH:  cfg_in.blit_width = csr_wdata[SIDE_REG_W-1:0];
            REG_BLIT_HEIGHT: cfg_in.blit_height = csr_wdata[SIDE_REG_W-1:0];
            REG_FG_INDEX:    cfg_in.fg_index = csr_wdata[COLOR_W-1:0];
            REG_BG_INDEX:    cfg_in.bg_index = csr_wdata[COLOR_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // byte and row position, clipping of the last byte of a row
   mbe_walk #(
      .MAX_SIDE (MAX_SIDE)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_bits   (req.bitmap_byte),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_ctl   (s1_ctl),
      .out_y     (s1_y),
      .out_col0  (s1_col0)
   );

   // row start address and vertical clip
   mbe_rowaddr #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .MAX_SIDE      (MAX_SIDE)
   ) u_rowaddr (
      .clock        (clock),
      .reset        (reset),
      .fb_base      (cfg_ff.fb_base),
      .in_valid     (s1_valid),
      .in_ready     (s1_ready),
      .in_ctl       (s1_ctl),
      .in_y         (s1_y),
      .in_col0      (s1_col0),
      .out_valid    (s3_valid),
      .out_ready    (s3_ready),
      .out_ctl      (s3_ctl),
      .out_col0     (s3_col0),
      .out_row_addr (s3_row_addr),
      .out_row_on   (s3_row_on)
   );

   // eight lanes, one per bit, leftmost bit in lane zero
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      mbe_lane #(
         .SCREEN_WIDTH (SCREEN_WIDTH),
         .MAX_SIDE     (MAX_SIDE)
      ) u_lane (
         .lane_idx  (LANE_IDX_W'(g)),
         .pixel_bit (s3_ctl.bits[LANES-1-g]),
         .col0      (s3_col0),
         .dest_x    (cfg_ff.dest_x),
         .row_addr  (s3_row_addr),
         .row_on    (s3_row_on && cfg_ff.enabled),
         .fg_index  (cfg_ff.fg_index),
         .bg_index  (cfg_ff.bg_index),
         .px        (lane_px[g])
      );
   end

   // lane results go out one pixel word per clock while rsp is ready
   mbe_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s3_valid),
      .in_ready (s3_ready),
      .in_ctl   (s3_ctl),
      .in_px    (lane_px),
      .rsp      (rsp)
   );

endmodule

`default_nettype wire
